// ----- design/pfi_pkg.sv -----
// Shared types and constants of the polyphase fractional interpolator.
// Used by the top level, pfi_ctrl and pfi_cmac; depends on nothing.
`default_nettype none

package pfi_pkg;

  localparam int TAPS       = 8;
  localparam int PHASES     = 16;
  localparam int LINE_DEPTH = 1024;

  localparam int LINE_AW  = $clog2(LINE_DEPTH);
  localparam int COEF_AW  = $clog2(PHASES * TAPS);
  localparam int PHASE_W  = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int TAP_W    = $clog2(TAPS);
  localparam int IDX_W    = 12;
  localparam int ACC_W    = 36;
  localparam int SMP_W    = 32;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 72;
  localparam int MAXPOS_W = 11;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_COEF   = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [9:0]         sample_index;
    logic [3:0]         coef_phase;
    logic [2:0]         coef_tap;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic [9:0]         position_int;
    logic [15:0]        position_frac;
  } item_t;

  // Control beat from the sequencer to the complex multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic valid;
    logic take;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ----- design/polyphase_fractional_interpolator.sv -----
// Polyphase fractional-delay interpolator for complex samples.
// Input beats (s_*) carry a kind in s_tuser: sample write, coefficient write or query.
// A sample write stores one complex Q1.15 value in the line, a coefficient write
// stores one complex Q2.14 value in the bank; neither gives an output.
// A query picks a phase from the top bits of the fraction and sums TAPS-1 complex
// products of that phase's coefficients with the samples around position_int.
// Samples below index zero, at or above max_position or past the line's end are left out of the sum.
// A query occupies the block while it takes the beat, steps through TAPS-1 taps in which
// one complex multiply-accumulate unit takes one tap a cycle, waits out the RAM read and
// the product/accumulate registers, and hands the sum to the output.
// The result beat (m_*) sits in an output register; while the block is idle it keeps
// taking beats, and a finished query holds s_tready low until the register frees.
// max_position is written over the APB port at address 0; pready is always high.
// Reset clears the control state and max_position; the stores keep their contents
// and must be written before they are read.
// Depends on pfi_pkg, pfi_ctrl, pfi_cmac and pfi_ram.
`default_nettype none

module polyphase_fractional_interpolator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  // input beats
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // s_tdata: sample_index[9:0], coef_phase[13:10], coef_tap[16:14], value_re[32:17],
  //          value_im[48:33], position_int[58:49], position_frac[74:59], zero pad
  input  wire logic [pfi_pkg::S_DATA_W-1:0]   s_tdata,
  // s_tuser: kind[1:0]
  input  wire logic [1:0]                     s_tuser,
  // result beats
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // m_tdata: result_re[35:0], result_im[71:36]
  output logic      [pfi_pkg::M_DATA_W-1:0]   m_tdata
);

  logic [pfi_pkg::MAXPOS_W-1:0] max_position;
  pfi_pkg::item_t               item;
  pfi_pkg::kind_t               kind;
  pfi_pkg::mac_ctl_t            mac_ctl;

  logic                         samp_we, coef_we, mac_done, out_load, out_free;
  logic [pfi_pkg::LINE_AW-1:0]  samp_waddr, samp_raddr;
  logic [pfi_pkg::COEF_AW-1:0]  coef_waddr, coef_raddr;
  logic [pfi_pkg::SMP_W-1:0]    wdata, samp_rdata, coef_rdata;
  logic signed [pfi_pkg::ACC_W-1:0] acc_re, acc_im;
  logic                         cfg_wr;

  assign item.sample_index  = s_tdata[9:0];
  assign item.coef_phase    = s_tdata[13:10];
  assign item.coef_tap      = s_tdata[16:14];
  assign item.value_re      = $signed(s_tdata[32:17]);
  assign item.value_im      = $signed(s_tdata[48:33]);
  assign item.position_int  = s_tdata[58:49];
  assign item.position_frac = s_tdata[74:59];
  assign kind               = pfi_pkg::kind_t'(s_tuser);

  // Register file: one register at word 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(max_position) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_position <= '0;
    end else if (cfg_wr) begin
      max_position <= pwdata[pfi_pkg::MAXPOS_W-1:0];
    end
  end

  pfi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .kind         (kind),
    .item         (item),
    .max_position (max_position),
    .samp_we      (samp_we),
    .samp_waddr   (samp_waddr),
    .samp_raddr   (samp_raddr),
    .coef_we      (coef_we),
    .coef_waddr   (coef_waddr),
    .coef_raddr   (coef_raddr),
    .wdata        (wdata),
    .mac_ctl      (mac_ctl),
    .mac_done     (mac_done),
    .out_free     (out_free),
    .out_load     (out_load)
  );

  pfi_ram #(
    .DEPTH (pfi_pkg::LINE_DEPTH),
    .WIDTH (pfi_pkg::SMP_W)
  ) u_sample_line (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_waddr),
    .wdata (wdata),
    .raddr (samp_raddr),
    .rdata (samp_rdata)
  );

  pfi_ram #(
    .DEPTH (pfi_pkg::PHASES * pfi_pkg::TAPS),
    .WIDTH (pfi_pkg::SMP_W)
  ) u_coef_bank (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  pfi_cmac u_cmac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .sample (samp_rdata),
    .coef   (coef_rdata),
    .done   (mac_done),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  // Output register: free when empty or when the current beat leaves now.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {acc_im, acc_re};
    end
  end

endmodule

`default_nettype wire

// ----- design/pfi_ram.sv -----
// Simple dual-port RAM with registered read data.
// Generic; holds the sample line and the coefficient bank.
`default_nettype none

module pfi_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/pfi_cmac.sv -----
// Shared complex multiply-accumulate unit: product stage, then accumulate.
// Depends on pfi_pkg for the control struct and widths.
`default_nettype none

module pfi_cmac (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pfi_pkg::mac_ctl_t                 ctl,
  input  wire logic [pfi_pkg::SMP_W-1:0]         sample,
  input  wire logic [pfi_pkg::SMP_W-1:0]         coef,
  output logic                                   done,
  output logic signed [pfi_pkg::ACC_W-1:0]       acc_re,
  output logic signed [pfi_pkg::ACC_W-1:0]       acc_im
);

  pfi_pkg::mac_ctl_t ctl_d;
  pfi_pkg::mac_ctl_t ctl_p;

  logic signed [15:0] sr, si, cr, ci;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [pfi_pkg::ACC_W-1:0] term_re, term_im;

  assign sr = $signed(sample[15:0]);
  assign si = $signed(sample[31:16]);
  assign cr = $signed(coef[15:0]);
  assign ci = $signed(coef[31:16]);

  // Control follows RAM read latency, then the product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d <= '0;
      ctl_p <= '0;
      done  <= 1'b0;
    end else begin
      ctl_d <= ctl;
      ctl_p <= ctl_d;
      done  <= ctl_p.valid && ctl_p.last;
    end
  end

  always_ff @(posedge clk) begin
    p_rr <= cr * sr;
    p_ii <= ci * si;
    p_ri <= cr * si;
    p_ir <= ci * sr;
  end

  assign term_re = pfi_pkg::ACC_W'(p_rr) - pfi_pkg::ACC_W'(p_ii);
  assign term_im = pfi_pkg::ACC_W'(p_ri) + pfi_pkg::ACC_W'(p_ir);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (ctl_p.valid && ctl_p.take) begin
      acc_re <= acc_re + term_re;
      acc_im <= acc_im + term_im;
    end
  end

endmodule

`default_nettype wire

// ----- design/pfi_ctrl.sv -----
// Sequencer: input handshake, store writes, tap addressing and result hand-off.
// Depends on pfi_pkg for states, kinds, the item struct and widths.
`default_nettype none

module pfi_ctrl (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire pfi_pkg::kind_t                     kind,
  input  wire pfi_pkg::item_t                     item,
  input  wire logic [pfi_pkg::MAXPOS_W-1:0]       max_position,
  output logic                                    samp_we,
  output logic [pfi_pkg::LINE_AW-1:0]             samp_waddr,
  output logic [pfi_pkg::LINE_AW-1:0]             samp_raddr,
  output logic                                    coef_we,
  output logic [pfi_pkg::COEF_AW-1:0]             coef_waddr,
  output logic [pfi_pkg::COEF_AW-1:0]             coef_raddr,
  output logic [pfi_pkg::SMP_W-1:0]               wdata,
  output pfi_pkg::mac_ctl_t                       mac_ctl,
  input  wire logic                               mac_done,
  input  wire logic                               out_free,
  output logic                                    out_load
);

  localparam logic [pfi_pkg::TAP_W-1:0] LAST_TAP = pfi_pkg::TAP_W'(pfi_pkg::TAPS - 2);

  pfi_pkg::state_t state, state_next;
  logic [pfi_pkg::TAP_W-1:0]          tap, tap_next;
  logic signed [pfi_pkg::IDX_W-1:0]   idx, idx_next;
  logic [pfi_pkg::COEF_AW-1:0]        coef_addr, coef_addr_next;

  logic [31:0]                        frac_scaled;
  logic [pfi_pkg::PHASE_W-1:0]        phase;
  logic signed [pfi_pkg::IDX_W-1:0]   base;
  logic                               in_line, in_bank, take;

  assign frac_scaled = 32'(item.position_frac) * 32'(pfi_pkg::PHASES);
  assign phase       = frac_scaled[16 +: pfi_pkg::PHASE_W];
  assign base        = $signed({2'b00, item.position_int})
                       - pfi_pkg::IDX_W'(pfi_pkg::TAPS / 2);

  assign in_line = 32'(item.sample_index) < pfi_pkg::LINE_DEPTH;
  assign in_bank = (32'(item.coef_phase) < pfi_pkg::PHASES) &&
                   (32'(item.coef_tap) < pfi_pkg::TAPS);

  // Skip taps outside the written window of the line.
  assign take = (idx >= 0) && (idx < $signed({1'b0, max_position})) &&
                (int'(idx) < pfi_pkg::LINE_DEPTH);

  assign samp_waddr = pfi_pkg::LINE_AW'(item.sample_index);
  assign coef_waddr = pfi_pkg::COEF_AW'(32'(item.coef_phase) * 32'(pfi_pkg::TAPS)
                                        + 32'(item.coef_tap));
  assign wdata      = {item.value_im, item.value_re};
  assign samp_raddr = pfi_pkg::LINE_AW'($unsigned(idx));
  assign coef_raddr = coef_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfi_pkg::ST_IDLE;
      tap       <= '0;
      idx       <= '0;
      coef_addr <= '0;
    end else begin
      state     <= state_next;
      tap       <= tap_next;
      idx       <= idx_next;
      coef_addr <= coef_addr_next;
    end
  end

  always_comb begin
    state_next     = state;
    tap_next       = tap;
    idx_next       = idx;
    coef_addr_next = coef_addr;
    s_tready       = 1'b0;
    samp_we        = 1'b0;
    coef_we        = 1'b0;
    mac_ctl        = '0;
    out_load       = 1'b0;
    case (state)
      pfi_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (kind)
            pfi_pkg::KIND_SAMPLE: samp_we = in_line;
            pfi_pkg::KIND_COEF:   coef_we = in_bank;
            pfi_pkg::KIND_QUERY: begin
              mac_ctl.clear  = 1'b1;
              tap_next       = '0;
              idx_next       = base;
              coef_addr_next = pfi_pkg::COEF_AW'(32'(phase) * 32'(pfi_pkg::TAPS));
              state_next     = pfi_pkg::ST_RUN;
            end
            default: ;
          endcase
        end
      end
      pfi_pkg::ST_RUN: begin
        mac_ctl.valid  = 1'b1;
        mac_ctl.take   = take;
        mac_ctl.last   = (tap == LAST_TAP);
        tap_next       = tap + pfi_pkg::TAP_W'(1);
        idx_next       = idx + pfi_pkg::IDX_W'(1);
        coef_addr_next = coef_addr + pfi_pkg::COEF_AW'(1);
        if (tap == LAST_TAP) begin
          state_next = pfi_pkg::ST_DRAIN;
        end
      end
      pfi_pkg::ST_DRAIN: begin
        if (mac_done) begin
          state_next = pfi_pkg::ST_EMIT;
        end
      end
      pfi_pkg::ST_EMIT: begin
        // Hold the sum until the output slot frees up.
        if (out_free) begin
          out_load   = 1'b1;
          state_next = pfi_pkg::ST_IDLE;
        end
      end
      default: state_next = pfi_pkg::ST_IDLE;
    endcase
  end

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && kind == pfi_pkg::KIND_QUERY) |=> state == pfi_pkg::ST_RUN)
    else $error("query beat did not start the tap sequence");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != pfi_pkg::ST_IDLE) |-> !(samp_we || coef_we))
    else $error("store write while a query is in flight");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == pfi_pkg::ST_DRAIN)
    else $error("accumulator finished outside the drain state");

endmodule

`default_nettype wire
